[rtl/lca_pkg.sv]
// ============================================================================
// lca_pkg - shared definitions for the life automaton count cache
// Item modes, cell word layout and the neighbor visiting order.
// ============================================================================
package lca_pkg;

    // Cell word: bit 0 is the alive bit, bits 4..1 the live-neighbor count.
    localparam int CELL_W  = 5;
    localparam int COUNT_W = 4;
    localparam int MODE_W  = 2;
    localparam int POS_W   = 6;
    localparam int POS_RANGE = 1 << POS_W;

    localparam logic [CELL_W-1:0] COUNT_ONE = 5'h02;

    // Item modes. The unused code behaves as a read.
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GEN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // Survival and birth counts.
    localparam logic [COUNT_W-1:0] KEEP_LO_COUNT = 4'd2;
    localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;

    // Update sequence: the center first, then the eight neighbors, then one
    // more step, the flush, to write back the last neighbor.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_CENTER    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST_NBR = 4'd1;
    localparam logic [STEP_W-1:0] STEP_FLUSH     = 4'd9;

    typedef enum logic [1:0] {
        OFS_PREV,
        OFS_SAME,
        OFS_NEXT
    } ofs_t;

    typedef struct packed {
        ofs_t dx;
        ofs_t dy;
    } nbr_ofs_t;

    function automatic nbr_ofs_t nbr_offset(input logic [STEP_W-1:0] step);
        nbr_ofs_t o;
        case (step)
            4'd1:    o = '{dx: OFS_PREV, dy: OFS_PREV};
            4'd2:    o = '{dx: OFS_SAME, dy: OFS_PREV};
            4'd3:    o = '{dx: OFS_NEXT, dy: OFS_PREV};
            4'd4:    o = '{dx: OFS_PREV, dy: OFS_SAME};
            4'd5:    o = '{dx: OFS_NEXT, dy: OFS_SAME};
            4'd6:    o = '{dx: OFS_PREV, dy: OFS_NEXT};
            4'd7:    o = '{dx: OFS_SAME, dy: OFS_NEXT};
            4'd8:    o = '{dx: OFS_NEXT, dy: OFS_NEXT};
            default: o = '{dx: OFS_SAME, dy: OFS_SAME};
        endcase
        return o;
    endfunction

endpackage

[rtl/life_automaton_count_cache.sv]
// ============================================================================
// life_automaton_count_cache - toroidal life grid with cached neighbor counts
//
// Items arrive on the s_ channel (s_mode, s_x_pos, s_y_pos) and each one
// yields exactly one result word on the m_ channel (m_cell_alive,
// m_neighbor_count). A toggle flips one cell and adjusts the counts of its
// eight wrapped neighbors; a read returns one cell; a generation advances
// the whole grid and answers with zeros. Coordinates are reduced modulo the
// grid side. Every cell lives in one memory word, and a second memory holds
// the snapshot that a generation works from.
//
// One item is processed at a time. A toggle does nine read-modify-writes
// through the single read and single write port of the cell memory, one
// word per cycle. A generation first copies all D words of the cell memory
// into the snapshot, where D = 2**(2*ceil(log2(GRID_SIDE))) (4096 at the
// default side), then walks every cell, reading it from the snapshot and
// checking it, and runs the nine-word update for each cell that changes.
//
// After reset the block clears the cell memory, one word per cycle, with
// s_ready low, and raises s_ready when the clearing pass is over. A
// finished result sits in an output register, and s_ready rises again once
// the result has moved into that register, so a stalled receiver holds back
// only the completion of the following item.
// ============================================================================
module life_automaton_count_cache import lca_pkg::*; #(
    parameter int GRID_SIDE = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MODE_W-1:0]  s_mode,
    input  logic [POS_W-1:0]   s_x_pos,
    input  logic [POS_W-1:0]   s_y_pos,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_cell_alive,
    output logic [COUNT_W-1:0] m_neighbor_count
);

    localparam int COORD_W = $clog2(GRID_SIDE);
    localparam int ADDR_W  = 2 * COORD_W;
    localparam logic [COORD_W-1:0] LAST = COORD_W'(GRID_SIDE - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_RD_DATA,
        ST_CHG,
        ST_COPY,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                is_gen_reg, is_gen_next;
    logic [COORD_W-1:0]  cx_reg, cx_next;
    logic [COORD_W-1:0]  cy_reg, cy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                live_reg, live_next;
    logic [ADDR_W-1:0]   wb_addr_reg, wb_addr_next;
    logic                res_alive_reg, res_alive_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;
    logic [ADDR_W:0]     cnt_reg, cnt_next;
    logic                copy_pend_reg, copy_pend_next;
    logic [ADDR_W-1:0]   copy_addr_reg, copy_addr_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_cell_alive_reg, m_cell_alive_next;
    logic [COUNT_W-1:0]  m_neighbor_count_reg, m_neighbor_count_next;

    // Coordinate reduction table, worked out at elaboration.
    logic [COORD_W-1:0]  coord_mod [POS_RANGE];
    for (genvar g = 0; g < POS_RANGE; g++) begin : g_mod
        assign coord_mod[g] = COORD_W'(g % GRID_SIDE);
    end

    // Memory ports.
    logic                cram_wr_en, cram_rd_en;
    logic [ADDR_W-1:0]   cram_wr_addr, cram_rd_addr;
    logic [CELL_W-1:0]   cram_wr_data, cram_rd_data;
    logic                sram_wr_en, sram_rd_en;
    logic [ADDR_W-1:0]   sram_wr_addr, sram_rd_addr;
    logic [CELL_W-1:0]   sram_wr_data, sram_rd_data;

    logic [ADDR_W-1:0]   center_addr;
    logic [ADDR_W-1:0]   nbr_addr;
    logic                live_eff;
    logic                snap_alive;
    logic [COUNT_W-1:0]  snap_count;
    logic                snap_change;
    logic [COORD_W-1:0]  adv_cx, adv_cy;
    logic                walk_done;

    lca_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_cell_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cram_wr_en),
        .wr_addr (cram_wr_addr),
        .wr_data (cram_wr_data),
        .rd_en   (cram_rd_en),
        .rd_addr (cram_rd_addr),
        .rd_data (cram_rd_data)
    );

    lca_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_snap_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (sram_wr_en),
        .wr_addr (sram_wr_addr),
        .wr_data (sram_wr_data),
        .rd_en   (sram_rd_en),
        .rd_addr (sram_rd_addr),
        .rd_data (sram_rd_data)
    );

    lca_nbr_addr #(
        .GRID_SIDE (GRID_SIDE)
    ) u_nbr_addr (
        .cx   (cx_reg),
        .cy   (cy_reg),
        .step (step_reg),
        .addr (nbr_addr)
    );

    assign center_addr = {cy_reg, cx_reg};

    // During a generation the direction is known from the snapshot; for a
    // toggle it is the inverse of the center's alive bit just read.
    assign live_eff = is_gen_reg ? live_reg : ~cram_rd_data[0];

    // A live cell survives on two or three neighbors; a dead one is born on
    // exactly three.
    assign snap_alive  = sram_rd_data[0];
    assign snap_count  = sram_rd_data[CELL_W-1:1];
    assign snap_change = snap_alive ? ((snap_count != KEEP_LO_COUNT) &&
                                       (snap_count != BIRTH_COUNT))
                                    : (snap_count == BIRTH_COUNT);

    // Walk position after the current cell: row by row, x fastest.
    assign adv_cx    = (cx_reg == LAST) ? '0 : cx_reg + COORD_W'(1);
    assign adv_cy    = (cx_reg == LAST) ? cy_reg + COORD_W'(1) : cy_reg;
    assign walk_done = (cx_reg == LAST) && (cy_reg == LAST);

    always_comb begin
        state_next            = state_reg;
        is_gen_next           = is_gen_reg;
        cx_next               = cx_reg;
        cy_next               = cy_reg;
        step_next             = step_reg;
        live_next             = live_reg;
        wb_addr_next          = wb_addr_reg;
        res_alive_next        = res_alive_reg;
        res_count_next        = res_count_reg;
        cnt_next              = cnt_reg;
        copy_pend_next        = copy_pend_reg;
        copy_addr_next        = copy_addr_reg;
        m_valid_next          = m_valid_reg && !m_ready;
        m_cell_alive_next     = m_cell_alive_reg;
        m_neighbor_count_next = m_neighbor_count_reg;

        cram_wr_en   = 1'b0;
        cram_wr_addr = wb_addr_reg;
        cram_wr_data = '0;
        cram_rd_en   = 1'b0;
        cram_rd_addr = center_addr;
        sram_wr_en   = 1'b0;
        sram_wr_addr = copy_addr_reg;
        sram_wr_data = cram_rd_data;
        sram_rd_en   = 1'b0;
        sram_rd_addr = center_addr;

        case (state_reg)
            ST_CLEAR: begin
                // Zero every word of the cell memory after reset.
                cram_wr_en   = !cnt_reg[ADDR_W];
                cram_wr_addr = cnt_reg[ADDR_W-1:0];
                cnt_next     = cnt_reg + (ADDR_W+1)'(1);
                if (cnt_reg[ADDR_W]) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    cx_next        = coord_mod[s_x_pos];
                    cy_next        = coord_mod[s_y_pos];
                    step_next      = STEP_CENTER;
                    cnt_next       = '0;
                    copy_pend_next = 1'b0;
                    is_gen_next    = (s_mode == MODE_GEN);
                    case (s_mode)
                        MODE_TOGGLE: state_next = ST_CHG;
                        MODE_GEN:    state_next = ST_COPY;
                        MODE_READ:   state_next = ST_RD;
                        default:     state_next = ST_RD;
                    endcase
                end
            end

            ST_RD: begin
                cram_rd_en = 1'b1;
                state_next = ST_RD_DATA;
            end

            ST_RD_DATA: begin
                res_alive_next = cram_rd_data[0];
                res_count_next = cram_rd_data[CELL_W-1:1];
                state_next     = ST_DONE;
            end

            ST_CHG: begin
                // Read one word per step up to the flush step and write back the one
                // read in the step before; all nine addresses are distinct.
                cram_rd_en   = (step_reg != STEP_FLUSH);
                cram_rd_addr = nbr_addr;
                wb_addr_next = nbr_addr;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg != STEP_CENTER) begin
                    cram_wr_en = 1'b1;
                    if (step_reg == STEP_FIRST_NBR) begin
                        cram_wr_data   = {cram_rd_data[CELL_W-1:1], live_eff};
                        live_next      = live_eff;
                        res_alive_next = live_eff;
                        res_count_next = cram_rd_data[CELL_W-1:1];
                    end else begin
                        cram_wr_data = live_reg ? cram_rd_data + COUNT_ONE
                                                : cram_rd_data - COUNT_ONE;
                    end
                end
                if (step_reg == STEP_FLUSH) begin
                    if (!is_gen_reg) begin
                        state_next = ST_DONE;
                    end else if (walk_done) begin
                        res_alive_next = 1'b0;
                        res_count_next = '0;
                        state_next     = ST_DONE;
                    end else begin
                        cx_next    = adv_cx;
                        cy_next    = adv_cy;
                        state_next = ST_WALK_RD;
                    end
                end
            end

            ST_COPY: begin
                // Stream the cell memory into the snapshot, one word a cycle.
                cram_rd_en     = !cnt_reg[ADDR_W];
                cram_rd_addr   = cnt_reg[ADDR_W-1:0];
                copy_pend_next = !cnt_reg[ADDR_W];
                copy_addr_next = cnt_reg[ADDR_W-1:0];
                sram_wr_en     = copy_pend_reg;
                cnt_next       = cnt_reg + (ADDR_W+1)'(1);
                if (cnt_reg[ADDR_W]) begin
                    cx_next    = '0;
                    cy_next    = '0;
                    state_next = ST_WALK_RD;
                end
            end

            ST_WALK_RD: begin
                sram_rd_en = 1'b1;
                state_next = ST_WALK_CHK;
            end

            ST_WALK_CHK: begin
                if (snap_change) begin
                    live_next  = ~snap_alive;
                    step_next  = STEP_CENTER;
                    state_next = ST_CHG;
                end else if (walk_done) begin
                    res_alive_next = 1'b0;
                    res_count_next = '0;
                    state_next     = ST_DONE;
                end else begin
                    cx_next    = adv_cx;
                    cy_next    = adv_cy;
                    state_next = ST_WALK_RD;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_cell_alive_next     = res_alive_reg;
                    m_neighbor_count_next = res_count_reg;
                    state_next            = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            copy_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            step_reg      <= STEP_CENTER;
            is_gen_reg    <= 1'b0;
            live_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            copy_pend_reg <= copy_pend_next;
            m_valid_reg   <= m_valid_next;
            step_reg      <= step_next;
            is_gen_reg    <= is_gen_next;
            live_reg      <= live_next;
        end
        cx_reg               <= cx_next;
        cy_reg               <= cy_next;
        wb_addr_reg          <= wb_addr_next;
        res_alive_reg        <= res_alive_next;
        res_count_reg        <= res_count_next;
        copy_addr_reg        <= copy_addr_next;
        m_cell_alive_reg     <= m_cell_alive_next;
        m_neighbor_count_reg <= m_neighbor_count_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_cell_alive     = m_cell_alive_reg;
    assign m_neighbor_count = m_neighbor_count_reg;

endmodule

[rtl/lca_ram.sv]
// ============================================================================
// lca_ram - simple dual-port memory with registered read
// One write and one read per cycle; a read of the address being written in
// the same cycle returns the new data.
// ============================================================================
module lca_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_q_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;

endmodule

[rtl/lca_nbr_addr.sv]
// ============================================================================
// lca_nbr_addr - wrapped neighbor address generator
// Turns a center cell and a sequence step into the memory address of the
// center or of one of its eight neighbors on the torus.
// ============================================================================
module lca_nbr_addr import lca_pkg::*; #(
    parameter  int GRID_SIDE = 64,
    localparam int COORD_W   = $clog2(GRID_SIDE)
) (
    input  logic [COORD_W-1:0]   cx,
    input  logic [COORD_W-1:0]   cy,
    input  logic [STEP_W-1:0]    step,
    output logic [2*COORD_W-1:0] addr
);

    localparam logic [COORD_W-1:0] LAST = COORD_W'(GRID_SIDE - 1);

    nbr_ofs_t           ofs;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;

    function automatic logic [COORD_W-1:0] wrap(input logic [COORD_W-1:0] c,
                                                input ofs_t o);
        logic [COORD_W-1:0] r;
        case (o)
            OFS_PREV: r = (c == '0) ? LAST : c - COORD_W'(1);
            OFS_NEXT: r = (c == LAST) ? '0 : c + COORD_W'(1);
            default:  r = c;
        endcase
        return r;
    endfunction

    assign ofs  = nbr_offset(step);
    assign nx   = wrap(cx, ofs.dx);
    assign ny   = wrap(cy, ofs.dy);
    assign addr = {ny, nx};

endmodule

[rtl/lca_checker.sv]
// ============================================================================
// lca_checker - port-level checks for the life automaton count cache
// Watches the top level's ports and flags reset, pacing and range slips.
// ============================================================================
module lca_checker import lca_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_cell_alive,
    input logic [COUNT_W-1:0] m_neighbor_count
);

    // Reset empties the output and starts the clearing pass.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("output valid or input ready right after reset");

    // Items are processed one at a time, so ready drops after each accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready stayed high after an accepted word");

    // A cached count can never exceed the eight neighbors.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_neighbor_count <= 4'd8)
        else $error("neighbor count above eight");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_alive) &&
                                $stable(m_neighbor_count))
        else $error("result word changed while stalled");

endmodule

bind life_automaton_count_cache lca_checker u_lca_checker (.*);

[test/tb_life_automaton_count_cache.sv]
// ----------------------------------------------------------------------------
// tb_life_automaton_count_cache - self-checking bench for the life grid
//
// Drives toggle, read and generation words into the block. A predictor keeps
// its own copy of the toroidal grid and the cached neighbor counts and works
// out the word that each item returns. Every returned word is compared with
// the oldest expected one. A short directed table covers the grid corners,
// wrapped neighbors, the spare mode and a small oscillator. Random episodes
// follow: most seed small windows, run generations over some and read back.
// ----------------------------------------------------------------------------
module tb_life_automaton_count_cache import lca_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_SIDE  = 64;
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;

    // The fourth mode code is unused by the block and must behave as a read.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Random items to send after the directed table.
    localparam int RANDOM_ITEMS = 1200;

    // A full-grid generation where every cell changes runs the update for
    // each cell after the snapshot copy, and the clearing pass after reset
    // writes each cell. The limit covers the worst case several times over.
    localparam int STALL_LIMIT = 250000;

    // Once nothing is expected any more, wait longer than a toggle
    // takes, so that a stray extra word would still show up.
    localparam int SETTLE_CYCLES = 40;

    // One word on the result channel.
    typedef struct packed {
        logic               alive;
        logic [COUNT_W-1:0] count;
    } cell_word_t;

    // One row of the directed table. Rows with has_word set carry an expected
    // word typed in by hand; the others are checked against the predictor.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic              has_word;
        cell_word_t        word;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // An empty grid reads back zero at both corners.
        '{MODE_READ,   6'd0,  6'd0,  1'b1, '{1'b0, 4'd0}},
        '{MODE_READ,   6'd63, 6'd63, 1'b1, '{1'b0, 4'd0}},
        // A live corner cell is a neighbor of the opposite corner.
        '{MODE_TOGGLE, 6'd0,  6'd0,  1'b1, '{1'b1, 4'd0}},
        '{MODE_READ,   6'd63, 6'd63, 1'b1, '{1'b0, 4'd1}},
        '{MODE_READ,   6'd1,  6'd1,  1'b1, '{1'b0, 4'd1}},
        '{MODE_TOGGLE, 6'd63, 6'd0,  1'b1, '{1'b1, 4'd1}},
        // The spare mode reads without changing the grid.
        '{MODE_SPARE,  6'd0,  6'd0,  1'b1, '{1'b1, 4'd1}},
        // A generation always answers with zeros; both lonely cells die.
        '{MODE_GEN,    6'd0,  6'd0,  1'b1, '{1'b0, 4'd0}},
        '{MODE_READ,   6'd0,  6'd0,  1'b1, '{1'b0, 4'd0}},
        // A blinker that straddles the left and right edges.
        '{MODE_TOGGLE, 6'd63, 6'd32, 1'b1, '{1'b1, 4'd0}},
        '{MODE_TOGGLE, 6'd0,  6'd32, 1'b1, '{1'b1, 4'd1}},
        '{MODE_TOGGLE, 6'd1,  6'd32, 1'b1, '{1'b1, 4'd1}},
        '{MODE_READ,   6'd0,  6'd31, 1'b0, '{1'b0, 4'd0}},
        '{MODE_GEN,    6'd0,  6'd0,  1'b1, '{1'b0, 4'd0}},
        '{MODE_READ,   6'd0,  6'd31, 1'b0, '{1'b0, 4'd0}},
        '{MODE_READ,   6'd63, 6'd32, 1'b0, '{1'b0, 4'd0}},
        '{MODE_GEN,    6'd63, 6'd63, 1'b1, '{1'b0, 4'd0}},
        '{MODE_READ,   6'd0,  6'd32, 1'b0, '{1'b0, 4'd0}},
        // Alternating coordinate bits on isolated cells that die next step.
        '{MODE_TOGGLE, 6'd42, 6'd21, 1'b1, '{1'b1, 4'd0}},
        '{MODE_TOGGLE, 6'd21, 6'd42, 1'b1, '{1'b1, 4'd0}},
        '{MODE_READ,   6'd42, 6'd21, 1'b1, '{1'b1, 4'd0}},
        '{MODE_GEN,    6'd21, 6'd42, 1'b1, '{1'b0, 4'd0}},
        '{MODE_READ,   6'd21, 6'd42, 1'b1, '{1'b0, 4'd0}},
        // Toggling a cell twice restores it.
        '{MODE_TOGGLE, 6'd63, 6'd63, 1'b1, '{1'b1, 4'd0}},
        '{MODE_TOGGLE, 6'd63, 6'd63, 1'b1, '{1'b0, 4'd0}}
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [MODE_W-1:0]  s_mode = MODE_READ;
    logic [POS_W-1:0]   s_x_pos = '0;
    logic [POS_W-1:0]   s_y_pos = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_cell_alive;
    logic [COUNT_W-1:0] m_neighbor_count;

    // The predictor's copy of the grid. The block clears its grid at reset,
    // and reset happens once, so the copy starts out cleared as well.
    logic [CELL_W-1:0] grid_cells     [CELL_COUNT] = '{default: '0};
    logic [CELL_W-1:0] grid_snapshot  [CELL_COUNT] = '{default: '0};

    cell_word_t expected_words [$];

    int items_sent    = 0;
    int words_checked = 0;
    int failures      = 0;
    int idle_cycles   = 0;
    int burst_left    = 0;

    life_automaton_count_cache #(
        .GRID_SIDE(GRID_SIDE)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_x_pos         (s_x_pos),
        .s_y_pos         (s_y_pos),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_alive    (m_cell_alive),
        .m_neighbor_count(m_neighbor_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Sets or clears one cell and moves the counts of its eight wrapped
    // neighbors by one. Counts live in the upper four bits of a five-bit
    // word, so the arithmetic wraps the same way the memory word does.
    function automatic void set_cell(input int x, input int y, input logic live);
        int xs [3];
        int ys [3];
        int nbr;
        xs[0] = (x + GRID_SIDE - 1) % GRID_SIDE;
        xs[1] = x;
        xs[2] = (x + 1) % GRID_SIDE;
        ys[0] = (y + GRID_SIDE - 1) % GRID_SIDE;
        ys[1] = y;
        ys[2] = (y + 1) % GRID_SIDE;
        grid_cells[y * GRID_SIDE + x][0] = live;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                if (i != 1 || j != 1) begin
                    nbr = ys[j] * GRID_SIDE + xs[i];
                    grid_cells[nbr] = live ? grid_cells[nbr] + COUNT_ONE
                                           : grid_cells[nbr] - COUNT_ONE;
                end
            end
        end
    endfunction

    // One generation. Decisions come from the snapshot taken at the start,
    // while the count updates land in the live grid as the walk goes on.
    function automatic void advance_grid();
        logic [CELL_W-1:0]  snap;
        logic [COUNT_W-1:0] count;
        grid_snapshot = grid_cells;
        for (int y = 0; y < GRID_SIDE; y++) begin
            for (int x = 0; x < GRID_SIDE; x++) begin
                snap  = grid_snapshot[y * GRID_SIDE + x];
                count = snap[CELL_W-1:1];
                if (snap[0]) begin
                    if (count != KEEP_LO_COUNT && count != BIRTH_COUNT) begin
                        set_cell(x, y, 1'b0);
                    end
                end else if (count == BIRTH_COUNT) begin
                    set_cell(x, y, 1'b1);
                end
            end
        end
    endfunction

    // Applies one item to the grid copy and returns the word it answers with.
    function automatic cell_word_t predict_word(input logic [MODE_W-1:0] mode,
                                                input logic [POS_W-1:0] x_in,
                                                input logic [POS_W-1:0] y_in);
        int x;
        int y;
        int idx;
        cell_word_t word;
        x   = int'(x_in) % GRID_SIDE;
        y   = int'(y_in) % GRID_SIDE;
        idx = y * GRID_SIDE + x;
        if (mode == MODE_GEN) begin
            advance_grid();
            return '0;
        end
        if (mode == MODE_TOGGLE) begin
            set_cell(x, y, !grid_cells[idx][0]);
        end
        word.alive = grid_cells[idx][0];
        word.count = grid_cells[idx][CELL_W-1:1];
        return word;
    endfunction

    // Offers one word on the input channel and returns at the falling edge
    // after it was taken. The sender works in bursts: when a burst runs out,
    // valid drops for a random gap, which is sometimes zero. Valid is only
    // lowered when the gap is real, so it never gets two updates in one step.
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y,
                             input logic has_word = 1'b0,
                             input cell_word_t typed_word = '0);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_x_pos <= x;
        s_y_pos <= y;
        do @(posedge aclk); while (!s_ready);
        // The predictor has to see every item so that its grid stays in step,
        // even where the table supplies the expected word itself.
        if (has_word) begin
            void'(predict_word(mode, x, y));
            expected_words.push_back(typed_word);
        end else begin
            expected_words.push_back(predict_word(mode, x, y));
        end
        items_sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    // The receiver plays a 16-bit ready pattern bit by bit and redraws it after
    // every fourth pass. A quarter of the patterns never stall; the others always
    // keep a ready in each half so that no stall lasts long.
    logic [15:0] ready_pattern = 16'hFFFF;
    int          ready_phase   = 0;

    always @(negedge aclk) begin
        if (ready_phase == 0) begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : 16'($urandom) | 16'h0101;
        end
        m_ready <= ready_pattern[ready_phase % 16];
        ready_phase = (ready_phase + 1) % 64;
    end

    // Result checking and the watchdog. Outputs are sampled at the rising edge
    // together with the handshake that moves them.
    always @(posedge aclk) begin
        cell_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result word %0d: alive=%0d count=%0d",
                             words_checked, m_cell_alive, m_neighbor_count);
                end
            end else begin
                want = expected_words.pop_front();
                if (want.alive !== m_cell_alive || want.count !== m_neighbor_count) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("result word %0d: expected alive=%0d count=%0d, got alive=%0d count=%0d",
                                 words_checked, want.alive, want.count,
                                 m_cell_alive, m_neighbor_count);
                    end
                end
            end
            words_checked++;
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int center_x;
        int center_y;
        int span;
        int count;
        int roll;
        logic [MODE_W-1:0] mode;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            send_item(DIRECTED[row].mode, DIRECTED[row].x, DIRECTED[row].y,
                      DIRECTED[row].has_word, DIRECTED[row].word);
        end

        // Random episodes. Most of them seed a small window with toggles,
        // sometimes run one or two generations over it, and read the window
        // and its border back. Half of the windows sit on a grid border so
        // that wrapped neighbors are exercised all the time. The remainder are
        // single words anywhere on the grid, in any mode, with a generation
        // kept rare because each one walks the whole grid.
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                if ($urandom_range(0, 1) == 1) begin
                    center_x = $urandom_range(0, GRID_SIDE - 1);
                    center_y = $urandom_range(0, GRID_SIDE - 1);
                end else begin
                    center_x = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2)
                                                           : $urandom_range(61, 63);
                    center_y = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2)
                                                           : $urandom_range(61, 63);
                end
                span  = $urandom_range(3, 5);
                count = $urandom_range(3, 10);
                repeat (count) begin
                    send_item(MODE_TOGGLE,
                              POS_W'((center_x + $urandom_range(0, span - 1)) % GRID_SIDE),
                              POS_W'((center_y + $urandom_range(0, span - 1)) % GRID_SIDE));
                end
                if ($urandom_range(0, 99) < 25) begin
                    count = $urandom_range(1, 2);
                    repeat (count) begin
                        send_item(MODE_GEN, POS_W'($urandom), POS_W'($urandom));
                    end
                end
                count = $urandom_range(2, 6);
                repeat (count) begin
                    mode = ($urandom_range(0, 7) == 0) ? MODE_SPARE : MODE_READ;
                    send_item(mode,
                              POS_W'((center_x + GRID_SIDE - 1
                                      + $urandom_range(0, span + 1)) % GRID_SIDE),
                              POS_W'((center_y + GRID_SIDE - 1
                                      + $urandom_range(0, span + 1)) % GRID_SIDE));
                end
            end else begin
                case ($urandom_range(0, 2))
                    0:       mode = MODE_TOGGLE;
                    1:       mode = MODE_READ;
                    default: mode = MODE_SPARE;
                endcase
                if ($urandom_range(0, 49) == 0) begin
                    mode = MODE_GEN;
                end
                send_item(mode, POS_W'($urandom), POS_W'($urandom));
            end
        end
        s_valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/lca_pkg.sv
rtl/lca_ram.sv
rtl/lca_nbr_addr.sv
rtl/life_automaton_count_cache.sv
rtl/lca_checker.sv
test/tb_life_automaton_count_cache.sv
